FILE: rtl/core/blex_pkg.sv
// Shared types and constants for the lexer with interning table.
// No dependencies.
package blex_pkg;

    localparam int KIND_W = 5;
    localparam int ERR_W = 2;

    localparam logic [4:0] K_ID = 5'd0;
    localparam logic [4:0] K_STRING = 5'd1;
    localparam logic [4:0] K_INTEGER = 5'd2;
    localparam logic [4:0] K_REAL = 5'd3;
    localparam logic [4:0] K_COLON = 5'd4;
    localparam logic [4:0] K_SHARP = 5'd5;
    localparam logic [4:0] K_OPEN = 5'd6;
    localparam logic [4:0] K_CLOSE = 5'd7;
    localparam logic [4:0] K_ASSIGN = 5'd8;
    localparam logic [4:0] K_COMMA = 5'd9;
    localparam logic [4:0] K_SEMI = 5'd10;
    localparam logic [4:0] K_NE = 5'd11;
    localparam logic [4:0] K_GT = 5'd12;
    localparam logic [4:0] K_GE = 5'd13;
    localparam logic [4:0] K_LT = 5'd14;
    localparam logic [4:0] K_LE = 5'd15;
    localparam logic [4:0] K_PLUS = 5'd16;
    localparam logic [4:0] K_MINUS = 5'd17;
    localparam logic [4:0] K_SLASH = 5'd18;
    localparam logic [4:0] K_STAR = 5'd19;
    localparam logic [4:0] K_CARET = 5'd20;
    localparam logic [4:0] K_NEWLINE = 5'd21;
    localparam logic [4:0] K_END = 5'd22;

    localparam logic [1:0] E_NONE = 2'd0;
    localparam logic [1:0] E_TRUNC = 2'd1;
    localparam logic [1:0] E_FULL = 2'd2;
    localparam logic [1:0] E_OPEN = 2'd3;

    localparam logic [7:0] C_CR = 8'd13;
    localparam logic [7:0] C_LF = 8'd10;
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_PERCENT = 8'h25;
    localparam logic [7:0] C_DOT = 8'h2e;
    localparam logic [7:0] C_QUOTE = 8'h22;

    typedef enum logic [2:0] {
        M_IDLE, M_AFTER_CR, M_STRING, M_NUMBER, M_IDENT, M_LESS, M_GREATER
    } scan_mode_t;

    typedef enum logic [3:0] {
        S_IN, S_DISPATCH, S_SEARCH_REQ, S_SEARCH_LEN, S_CMP, S_APPEND,
        S_OUT, S_RESTART, S_END
    } ctrl_state_t;

    typedef struct packed {
        logic [4:0] kind;
        logic [1:0] err;
        logic       has;
    } tok_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            8'h3a: return {1'b1, K_COLON};
            8'h23: return {1'b1, K_SHARP};
            8'h28: return {1'b1, K_OPEN};
            8'h29: return {1'b1, K_CLOSE};
            8'h3d: return {1'b1, K_ASSIGN};
            8'h2c: return {1'b1, K_COMMA};
            8'h3b: return {1'b1, K_SEMI};
            8'h2b: return {1'b1, K_PLUS};
            8'h2d: return {1'b1, K_MINUS};
            8'h2f: return {1'b1, K_SLASH};
            8'h2a: return {1'b1, K_STAR};
            8'h5e: return {1'b1, K_CARET};
            default: return 6'd0;
        endcase
    endfunction

endpackage

FILE: rtl/core/basic_lexer_with_interning.sv
// Top level of the lexer with interning symbol table.
// Depends on blex_pkg, blex_ctrl and blex_datapath.
//
// Channel  Dir  Payload
// s_axis   in   tdata = in_byte, tuser = end_of_input
// m_axis   out  tdata = symbol_index, tuser = {error_code, has_symbol, token_kind}, tlast
//
// A byte is taken in S_IN and dispatched in S_DISPATCH, its tokens go out in S_OUT, and
// a byte that ends a token is dispatched again in S_RESTART. The interning search reads
// each entry in S_SEARCH_REQ and S_SEARCH_LEN, with S_CMP per byte compared in an entry
// of equal length; a miss then appends one byte per cycle. Reset clears the scanner and
// the symbol count. Output stalls hold the sequencer; no input is taken meanwhile.
module basic_lexer_with_interning import blex_pkg::*; #(
    parameter int MAX_LEXEME = 32,
    parameter int SYMBOLS = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte
    input  logic s_axis_tuser,         // end_of_input
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [7:0] m_axis_tdata,   // symbol_index
    output logic [7:0] m_axis_tuser,   // token_kind, has_symbol, error_code
    output logic m_axis_tlast
);
    localparam int LW = $clog2(MAX_LEXEME + 1);
    localparam int CW = $clog2(SYMBOLS + 1);

    tok_t tok;
    logic [7:0] wr_byte;
    logic lex_clear, lex_push, rd_en, app_en, byte_eq;
    logic [CW-1:0] sym_idx;
    logic [LW-1:0] pos, lex_len, sym_len;

    blex_ctrl #(.MAX_LEXEME(MAX_LEXEME), .SYMBOLS(SYMBOLS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_byte(s_axis_tdata), .in_eoi(s_axis_tuser),
        .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_tok(tok), .out_idx(m_axis_tdata), .out_last(m_axis_tlast),
        .wr_byte(wr_byte), .lex_clear(lex_clear), .lex_push(lex_push),
        .sym_idx(sym_idx), .pos(pos), .rd_en(rd_en), .app_en(app_en),
        .lex_len(lex_len), .sym_len(sym_len), .byte_eq(byte_eq)
    );

    blex_datapath #(.MAX_LEXEME(MAX_LEXEME), .SYMBOLS(SYMBOLS)) u_dp (
        .clk(clk), .wr_byte(wr_byte), .lex_clear(lex_clear), .lex_push(lex_push),
        .sym_idx(sym_idx), .pos(pos), .rd_en(rd_en), .app_en(app_en),
        .lex_len(lex_len), .sym_len(sym_len), .byte_eq(byte_eq)
    );

    assign m_axis_tuser = {tok.err, tok.has, tok.kind};
endmodule

FILE: rtl/core/blex_datapath.sv
// Lexeme buffer, symbol table memories and search comparison.
// Depends on blex_pkg; driven by blex_ctrl.
module blex_datapath import blex_pkg::*; #(
    parameter int MAX_LEXEME = 32,
    parameter int SYMBOLS = 256
) (
    input  logic clk,
    input  logic [7:0] wr_byte,
    input  logic lex_clear,
    input  logic lex_push,
    input  logic [$clog2(SYMBOLS+1)-1:0] sym_idx,
    input  logic [$clog2(MAX_LEXEME+1)-1:0] pos,
    input  logic rd_en,
    input  logic app_en,
    output logic [$clog2(MAX_LEXEME+1)-1:0] lex_len,
    output logic [$clog2(MAX_LEXEME+1)-1:0] sym_len,
    output logic byte_eq
);
    localparam int LW = $clog2(MAX_LEXEME + 1);
    localparam int PW = (MAX_LEXEME > 1) ? $clog2(MAX_LEXEME) : 1;
    localparam int SW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int AW = SW + PW;

    logic [7:0] lex_mem [MAX_LEXEME];
    logic [7:0] sym_mem [SYMBOLS * (2 ** PW)];
    logic [LW-1:0] len_mem [SYMBOLS];
    logic [LW-1:0] len_reg;
    logic [7:0] lex_q_reg;
    logic [7:0] sym_q_reg;
    logic [LW-1:0] slen_reg;
    logic [AW-1:0] addr;

    assign addr = {sym_idx[SW-1:0], pos[PW-1:0]};

    always_ff @(posedge clk)
    begin
        if (lex_clear)
        begin
            // A clear together with a push starts a new lexeme with this byte.
            len_reg <= lex_push ? LW'(1) : '0;
            if (lex_push)
                lex_mem[0] <= wr_byte;
        end
        else if (lex_push)
        begin
            lex_mem[len_reg[PW-1:0]] <= wr_byte;
            len_reg <= len_reg + LW'(1);
        end
        if (rd_en)
        begin
            lex_q_reg <= lex_mem[pos[PW-1:0]];
            sym_q_reg <= sym_mem[addr];
            slen_reg <= len_mem[sym_idx[SW-1:0]];
        end
        if (app_en)
        begin
            sym_mem[addr] <= lex_mem[pos[PW-1:0]];
            if (pos == '0)
                len_mem[sym_idx[SW-1:0]] <= len_reg;
        end
    end

    assign lex_len = len_reg;
    assign sym_len = slen_reg;
    assign byte_eq = lex_q_reg == sym_q_reg;
endmodule

FILE: rtl/core/blex_ctrl.sv
// Scanner state machine and interning sequencer.
// Depends on blex_pkg; commands blex_datapath.
module blex_ctrl import blex_pkg::*; #(
    parameter int MAX_LEXEME = 32,
    parameter int SYMBOLS = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic [7:0] in_byte,
    input  logic in_eoi,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output tok_t out_tok,
    output logic [7:0] out_idx,
    output logic out_last,
    output logic [7:0] wr_byte,
    output logic lex_clear,
    output logic lex_push,
    output logic [$clog2(SYMBOLS+1)-1:0] sym_idx,
    output logic [$clog2(MAX_LEXEME+1)-1:0] pos,
    output logic rd_en,
    output logic app_en,
    input  logic [$clog2(MAX_LEXEME+1)-1:0] lex_len,
    input  logic [$clog2(MAX_LEXEME+1)-1:0] sym_len,
    input  logic byte_eq
);
    localparam int LW = $clog2(MAX_LEXEME + 1);
    localparam int CW = $clog2(SYMBOLS + 1);

    ctrl_state_t state_reg, state_next;
    scan_mode_t mode_reg, mode_next;
    logic dot_reg, dot_next, trunc_reg, trunc_next;
    logic [7:0] c_reg, c_next;
    logic eoi_reg, eoi_next;
    logic [CW-1:0] cnt_reg, cnt_next, idx_reg, idx_next;
    logic [LW-1:0] pos_reg, pos_next;
    tok_t tok_reg, tok_next;
    logic [7:0] oidx_reg, oidx_next;
    logic olast_reg, olast_next;
    logic after_reg, after_next;
    logic [1:0] then_reg, then_next;
    logic [4:0] wkind_reg, wkind_next;

    localparam logic [1:0] T_DONE = 2'd0;
    localparam logic [1:0] T_RESTART = 2'd1;
    localparam logic [1:0] T_END = 2'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IN;
            mode_reg <= M_IDLE;
            dot_reg <= 1'b0;
            trunc_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg <= mode_next;
            dot_reg <= dot_next;
            trunc_reg <= trunc_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        eoi_reg <= eoi_next;
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        tok_reg <= tok_next;
        oidx_reg <= oidx_next;
        olast_reg <= olast_next;
        after_reg <= after_next;
        then_reg <= then_next;
        wkind_reg <= wkind_next;
    end

    assign out_tok = tok_reg;
    assign out_idx = oidx_reg;
    assign out_last = olast_reg;
    assign sym_idx = idx_reg;
    assign pos = pos_reg;
    assign wr_byte = c_reg;

    always_comb
    begin
        logic [5:0] sk;
        logic [LW-1:0] lim;
        state_next = state_reg;
        mode_next = mode_reg;
        dot_next = dot_reg;
        trunc_next = trunc_reg;
        c_next = c_reg;
        eoi_next = eoi_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        tok_next = tok_reg;
        oidx_next = oidx_reg;
        olast_next = olast_reg;
        after_next = after_reg;
        then_next = then_reg;
        wkind_next = wkind_reg;
        in_ready = 1'b0;
        out_valid = 1'b0;
        lex_clear = 1'b0;
        lex_push = 1'b0;
        rd_en = 1'b0;
        app_en = 1'b0;
        sk = single_kind(c_reg);
        lim = LW'(MAX_LEXEME);
        case (state_reg)
            S_IN:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    c_next = in_byte;
                    eoi_next = in_eoi;
                    state_next = in_eoi ? S_END : S_DISPATCH;
                end
            end
            S_DISPATCH, S_RESTART:
            begin
                // In S_RESTART the byte starts a new token from idle.
                state_next = S_IN;
                then_next = T_DONE;
                after_next = state_reg == S_RESTART;
                tok_next = '{kind: K_END, err: E_NONE, has: 1'b0};
                oidx_next = '0;
                olast_next = 1'b1;
                if (state_reg == S_RESTART || mode_reg == M_IDLE)
                begin
                    mode_next = M_IDLE;
                    if (c_reg == C_CR)
                    begin
                        tok_next.kind = K_NEWLINE;
                        mode_next = M_AFTER_CR;
                        state_next = S_OUT;
                    end
                    else if (c_reg == C_QUOTE || is_digit(c_reg) || is_letter(c_reg))
                    begin
                        lex_clear = 1'b1;
                        lex_push = 1'b1;
                        trunc_next = 1'b0;
                        dot_next = 1'b0;
                        mode_next = c_reg == C_QUOTE ? M_STRING :
                                    is_digit(c_reg) ? M_NUMBER : M_IDENT;
                    end
                    else if (sk[5])
                    begin
                        tok_next.kind = sk[4:0];
                        state_next = S_OUT;
                    end
                    else if (c_reg == 8'h3c)
                        mode_next = M_LESS;
                    else if (c_reg == 8'h3e)
                        mode_next = M_GREATER;
                end
                else
                begin
                    case (mode_reg)
                        M_AFTER_CR:
                        begin
                            mode_next = M_IDLE;
                            if (c_reg != C_LF)
                                state_next = S_RESTART;
                        end
                        M_STRING:
                        begin
                            if (c_reg != C_QUOTE)
                                lim = LW'(MAX_LEXEME - 1);
                            if (lex_len < lim)
                                lex_push = 1'b1;
                            else
                                trunc_next = 1'b1;
                            if (c_reg == C_QUOTE)
                            begin
                                wkind_next = K_STRING;
                                mode_next = M_IDLE;
                                state_next = S_SEARCH_REQ;
                            end
                        end
                        M_NUMBER:
                        begin
                            if (is_digit(c_reg) || (c_reg == C_DOT && !dot_reg))
                            begin
                                if (c_reg == C_DOT)
                                    dot_next = 1'b1;
                                if (lex_len < lim)
                                    lex_push = 1'b1;
                                else
                                    trunc_next = 1'b1;
                            end
                            else
                            begin
                                wkind_next = dot_reg ? K_REAL : K_INTEGER;
                                then_next = T_RESTART;
                                state_next = S_SEARCH_REQ;
                            end
                        end
                        M_IDENT:
                        begin
                            if (is_letter(c_reg) || c_reg == C_DOLLAR ||
                                c_reg == C_PERCENT)
                            begin
                                if (is_letter(c_reg))
                                    lim = LW'(MAX_LEXEME - 1);
                                if (lex_len < lim)
                                    lex_push = 1'b1;
                                else
                                    trunc_next = 1'b1;
                                if (!is_letter(c_reg))
                                begin
                                    wkind_next = K_ID;
                                    mode_next = M_IDLE;
                                    state_next = S_SEARCH_REQ;
                                end
                            end
                            else
                            begin
                                wkind_next = K_ID;
                                then_next = T_RESTART;
                                state_next = S_SEARCH_REQ;
                            end
                        end
                        M_LESS, M_GREATER:
                        begin
                            mode_next = M_IDLE;
                            state_next = S_OUT;
                            if (c_reg == 8'h3d)
                                tok_next.kind = mode_reg == M_LESS ? K_LE : K_GE;
                            else if ((mode_reg == M_LESS && c_reg == 8'h3e) ||
                                     (mode_reg == M_GREATER && c_reg == 8'h3c))
                                tok_next.kind = K_NE;
                            else
                            begin
                                tok_next.kind = mode_reg == M_LESS ? K_LT : K_GT;
                                olast_next = !(c_reg == C_CR || sk[5]);
                                then_next = T_RESTART;
                            end
                        end
                        default: mode_next = M_IDLE;
                    endcase
                end
                if (state_next == S_SEARCH_REQ)
                begin
                    idx_next = '0;
                    pos_next = '0;
                    // Only a carriage return or an operator byte gives a second token.
                    if (then_next == T_RESTART)
                        olast_next = !(c_reg == C_CR || sk[5]);
                end
            end
            S_END:
            begin
                after_next = 1'b0;
                oidx_next = '0;
                then_next = T_END;
                olast_next = 1'b0;
                idx_next = '0;
                pos_next = '0;
                state_next = S_OUT;
                tok_next = '{kind: K_END, err: E_NONE, has: 1'b0};
                mode_next = M_IDLE;
                case (mode_reg)
                    M_STRING: tok_next = '{kind: K_STRING, err: E_OPEN, has: 1'b0};
                    M_NUMBER:
                    begin
                        wkind_next = dot_reg ? K_REAL : K_INTEGER;
                        state_next = S_SEARCH_REQ;
                    end
                    M_IDENT:
                    begin
                        wkind_next = K_ID;
                        state_next = S_SEARCH_REQ;
                    end
                    M_LESS: tok_next.kind = K_LT;
                    M_GREATER: tok_next.kind = K_GT;
                    default:
                    begin
                        then_next = T_DONE;
                        olast_next = 1'b1;
                    end
                endcase
                dot_next = 1'b0;
            end
            S_SEARCH_REQ:
            begin
                if (idx_reg == cnt_reg)
                begin
                    tok_next.kind = wkind_reg;
                    if (cnt_reg == CW'(SYMBOLS))
                    begin
                        tok_next.has = 1'b0;
                        tok_next.err = E_FULL;
                        oidx_next = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        pos_next = '0;
                        state_next = S_APPEND;
                    end
                end
                else
                begin
                    rd_en = 1'b1;
                    state_next = S_SEARCH_LEN;
                end
            end
            S_SEARCH_LEN:
            begin
                if (sym_len == lex_len && pos_reg == lex_len)
                begin
                    tok_next = '{kind: wkind_reg, err: trunc_reg ? E_TRUNC : E_NONE,
                                 has: 1'b1};
                    oidx_next = 8'(idx_reg);
                    state_next = S_OUT;
                end
                else if (sym_len != lex_len || !byte_eq)
                begin
                    idx_next = idx_reg + CW'(1);
                    pos_next = '0;
                    state_next = S_SEARCH_REQ;
                end
                else
                begin
                    pos_next = pos_reg + LW'(1);
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (pos_reg == lex_len)
                    state_next = S_SEARCH_LEN;
                else
                begin
                    rd_en = 1'b1;
                    state_next = S_SEARCH_LEN;
                end
            end
            S_APPEND:
            begin
                app_en = 1'b1;
                pos_next = pos_reg + LW'(1);
                if (pos_reg + LW'(1) >= lex_len)
                begin
                    tok_next = '{kind: wkind_reg, err: trunc_reg ? E_TRUNC : E_NONE,
                                 has: 1'b1};
                    oidx_next = 8'(idx_reg);
                    cnt_next = cnt_reg + CW'(1);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (then_reg == T_RESTART)
                        state_next = S_RESTART;
                    else if (then_reg == T_END)
                    begin
                        tok_next = '{kind: K_END, err: E_NONE, has: 1'b0};
                        oidx_next = '0;
                        olast_next = 1'b1;
                        then_next = T_DONE;
                        trunc_next = 1'b0;
                    end
                    else
                        state_next = S_IN;
                end
            end
            default: state_next = S_IN;
        endcase
        if (after_reg)
            after_next = 1'b0;
    end
endmodule

FILE: rtl/core/blex_checks.sv
// Port-level checks for the lexer, bound to the top level.
// Depends on blex_pkg.
module blex_checks import blex_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [7:0] m_axis_tuser,
    input logic m_axis_tlast
);
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready during output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
        else $error("output dropped");
    a_nosym: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[5] |-> m_axis_tdata == 8'd0)
        else $error("index without symbol");
    a_endlast: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[4:0] == K_END |-> m_axis_tlast)
        else $error("end not last");
endmodule

bind basic_lexer_with_interning blex_checks u_checks (.*);
